### src/skl_pkg.sv
// Shared types and constants for the sorted keyed latest table.
`default_nettype none

package skl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int TIME_W       = 32;
  localparam int HANDLE_W     = 32;
  localparam int STATUS_W     = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_NOMSG    = 3'd3,
    ST_FULL     = 3'd4,
    ST_FLUSHED  = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  // One table entry as held in a cell.
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   tstamp;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_CMP     = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_SHIFT   = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   tstamp;
    logic [HANDLE_W-1:0] handle;
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/skl_cell.sv
// One cell of the sorted table chain: an entry plus its compare flags.
`default_nettype none

module skl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  skl_pkg::cell_ctl_t ctl,
  input  skl_pkg::entry_t    prev_entry,
  input  logic               prev_lt,
  input  skl_pkg::entry_t    next_entry,
  output skl_pkg::entry_t    entry,
  output logic               lt,
  output logic               eq,
  output logic               newer
);
  import skl_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   lt_r, lt_nxt;
  logic   eq_r, eq_nxt;
  logic   newer_r, newer_nxt;

  always_comb begin
    entry_nxt = entry_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    newer_nxt = newer_r;
    case (ctl.cmd)
      CMD_CMP: begin
        lt_nxt    = entry_r.valid && (entry_r.key < ctl.key);
        eq_nxt    = entry_r.valid && (entry_r.key == ctl.key);
        newer_nxt = entry_r.tstamp < ctl.tstamp;
      end
      CMD_INSERT: begin
        // Cells below the insert point hold; the insert point loads the new
        // entry; everything above moves up by one.
        if (!lt_r) begin
          if (prev_lt) begin
            entry_nxt.valid  = 1'b1;
            entry_nxt.key    = ctl.key;
            entry_nxt.tstamp = ctl.tstamp;
            entry_nxt.handle = ctl.handle;
          end else begin
            entry_nxt = prev_entry;
          end
        end
      end
      CMD_REPLACE: begin
        if (eq_r) begin
          entry_nxt.tstamp = ctl.tstamp;
          entry_nxt.handle = ctl.handle;
        end
      end
      CMD_SHIFT: begin
        entry_nxt = next_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      lt_r          <= 1'b0;
      eq_r          <= 1'b0;
      newer_r       <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
      newer_r <= newer_nxt;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;
  assign newer = newer_r;

endmodule

`default_nettype wire

### src/sorted_keyed_latest_table.sv
// Top level of the sorted keyed latest table: control and the chain of cells.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per
// request: an add (opcode 0) or a flush (opcode 1). The result channel
// (out_valid / out_stall) returns one transaction per add, and one per stored
// entry on a flush (or one empty status), with out_last on the final one.
// After acceptance, an add first broadcasts the key and every cell
// registers its compare flags; then, once the output register is free, the
// cells insert, shift or replace in one step while the result is registered.
// A flush offers one entry per cycle while the receiver does not stall, in
// ascending key order, shifting the whole chain toward cell 0 for each
// entry taken. One request is in flight at a time; the next is accepted
// once the current one has produced its last result into the output
// register, even while that result still waits.
// Reset empties the table at once (all cell valid bits clear) and drops any
// pending result. While the receiver stalls, the output register holds its
// transaction and the cell entries hold as well: no shift, no update.
`default_nettype none

module sorted_keyed_latest_table #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [skl_pkg::KEY_W-1:0]    in_item_key,
  input  logic [skl_pkg::TIME_W-1:0]   in_time_sec,
  input  logic                         in_has_message,
  input  logic [skl_pkg::HANDLE_W-1:0] in_message_handle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skl_pkg::STATUS_W-1:0] out_status,
  output logic [skl_pkg::KEY_W-1:0]    out_key,
  output logic [skl_pkg::TIME_W-1:0]   out_time,
  output logic [skl_pkg::HANDLE_W-1:0] out_handle,
  output logic                         out_last
);
  import skl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_ADD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Request captured at acceptance.
  logic [KEY_W-1:0]    key_r;
  logic [TIME_W-1:0]   tstamp_r;
  logic [HANDLE_W-1:0] handle_r;
  logic                has_msg_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, status_nxt;
  logic [KEY_W-1:0]    out_key_r, key_nxt;
  logic [TIME_W-1:0]   out_time_r, time_nxt;
  logic [HANDLE_W-1:0] out_handle_r, handle_nxt;
  logic                out_last_r, last_nxt;

  // Chain wiring.
  cell_ctl_t           ctl;
  cell_cmd_t           cmd;
  entry_t              entry_arr [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec, newer_vec;

  logic                accept;
  logic                slot_free;
  logic                load;
  logic                any_eq, any_newer, full;
  logic [TIME_W-1:0]   kept_time;
  logic [HANDLE_W-1:0] kept_handle;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign ctl.cmd    = cmd;
  assign ctl.key    = key_r;
  assign ctl.tstamp = tstamp_r;
  assign ctl.handle = handle_r;

  // Build the chain: cell 0 holds the smallest key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_l;
    if (g == 0) begin : g_first
      assign prev_e = '0;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = entry_arr[g-1];
      assign prev_l = lt_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry_arr[g+1];
    end
    skl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_entry (prev_e),
      .prev_lt    (prev_l),
      .next_entry (next_e),
      .entry      (entry_arr[g]),
      .lt         (lt_vec[g]),
      .eq         (eq_vec[g]),
      .newer      (newer_vec[g])
    );
  end

  // Match summary; at most one cell can match since keys are unique.
  assign any_eq    = |eq_vec;
  assign any_newer = |(eq_vec & newer_vec);
  assign full      = entry_arr[CAPACITY-1].valid;

  always_comb begin
    kept_time   = '0;
    kept_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      kept_time   = kept_time   | (entry_arr[i].tstamp & {TIME_W{eq_vec[i]}});
      kept_handle = kept_handle | (entry_arr[i].handle & {HANDLE_W{eq_vec[i]}});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = CMD_HOLD;
    load       = 1'b0;
    status_nxt = ST_EMPTY;
    key_nxt    = '0;
    time_nxt   = '0;
    handle_nxt = '0;
    last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_opcode ? S_FLUSH : S_CMP;
        end
      end
      S_CMP: begin
        // Broadcast the key; every cell registers its compare flags.
        cmd       = CMD_CMP;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (slot_free) begin
          load      = 1'b1;
          key_nxt   = key_r;
          state_nxt = S_IDLE;
          if (!has_msg_r) begin
            status_nxt = ST_NOMSG;
          end else if (any_eq) begin
            if (any_newer) begin
              status_nxt = ST_REPLACED;
              time_nxt   = tstamp_r;
              handle_nxt = handle_r;
              cmd        = CMD_REPLACE;
            end else begin
              status_nxt = ST_KEPT;
              time_nxt   = kept_time;
              handle_nxt = kept_handle;
            end
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_INSERTED;
            time_nxt   = tstamp_r;
            handle_nxt = handle_r;
            cmd        = CMD_INSERT;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          load = 1'b1;
          if (!entry_arr[0].valid) begin
            // Empty table on the first flush step.
            status_nxt = ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            // Emit cell 0 and advance the chain toward it.
            status_nxt = ST_FLUSHED;
            key_nxt    = entry_arr[0].key;
            time_nxt   = entry_arr[0].tstamp;
            handle_nxt = entry_arr[0].handle;
            last_nxt   = !entry_arr[1].valid;
            cmd        = CMD_SHIFT;
            if (!entry_arr[1].valid) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture the request and the result without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r     <= in_item_key;
      tstamp_r  <= in_time_sec;
      handle_r  <= in_message_handle;
      has_msg_r <= in_has_message;
    end
    if (load) begin
      out_status_r <= status_nxt;
      out_key_r    <= key_nxt;
      out_time_r   <= time_nxt;
      out_handle_r <= handle_nxt;
      out_last_r   <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_time   = out_time_r;
  assign out_handle = out_handle_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire
